@@ hw/rtl/rle_text_encoder_macros.svh @@
// Assertion macros used by the checker file of the run-length text encoder.
`ifndef RLE_TEXT_ENCODER_MACROS_SVH
`define RLE_TEXT_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RTE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rle_text_encoder assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rle_text_encoder assertion failed");

`endif

@@ hw/rtl/rte_pkg.sv @@
// Types, constants and widths shared by the run-length text encoder modules.
package rte_pkg;

    localparam int COUNT_DIGITS = 5;
    localparam int COUNT_W      = 4 * COUNT_DIGITS;
    localparam int DIG_IDX_W    = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;
    localparam int POS_W        = $clog2(COUNT_DIGITS + 4);

    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = 2;
    localparam int FIFO_CNT_W   = 3;

    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // One finished run, ready to be spelled out as text.
    typedef struct packed {
        logic [7:0]           run_byte;
        logic [COUNT_W-1:0]   count;
        logic [DIG_IDX_W-1:0] top;
        logic                 last;
    } rte_run_rec_t;

    // Up to two finished runs produced by one accepted input beat.
    typedef struct packed {
        logic         vld0;
        rte_run_rec_t rec0;
        logic         vld1;
        rte_run_rec_t rec1;
    } rte_push_t;

endpackage

@@ hw/rtl/rte_run_tracker.sv @@
// Open-run state and the run records that each input beat finishes.
module rte_run_tracker
    import rte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output rte_push_t  push
);

    logic [7:0]         value_reg, value_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               open_reg, open_next;
    logic [COUNT_W-1:0] count_inc;
    logic               all_nines;

    function automatic logic [DIG_IDX_W-1:0] top_digit(input logic [COUNT_W-1:0] cnt);
        logic [DIG_IDX_W-1:0] idx;
        idx = '0;
        for (int d = 1; d < COUNT_DIGITS; d++)
        begin
            if (cnt[4*d +: 4] != 4'd0)
            begin
                idx = DIG_IDX_W'(d);
            end
        end
        return idx;
    endfunction

    // Decimal increment; the final carry out means every digit was a nine.
    always_comb
    begin
        logic carry;
        logic [3:0] dig;
        carry = 1'b1;
        count_inc = count_reg;
        for (int d = 0; d < COUNT_DIGITS; d++)
        begin
            dig = count_reg[4*d +: 4];
            if (carry)
            begin
                count_inc[4*d +: 4] = (dig == 4'd9) ? 4'd0 : dig + 4'd1;
            end
            carry = carry && (dig == 4'd9);
        end
        all_nines = carry;
    end

    always_comb
    begin
        value_next = value_reg;
        count_next = count_reg;
        open_next  = open_reg;
        push       = '0;
        if (accept)
        begin
            if (!open_reg)
            begin
                value_next = in_byte;
                count_next = COUNT_W'(1);
                open_next  = 1'b1;
            end
            else if (in_byte == value_reg)
            begin
                if (all_nines)
                begin
                    push.vld0  = 1'b1;
                    push.rec0  = '{run_byte: value_reg, count: count_reg,
                                   top: top_digit(count_reg), last: !in_last};
                    count_next = COUNT_W'(1);
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            else
            begin
                push.vld0  = 1'b1;
                push.rec0  = '{run_byte: value_reg, count: count_reg,
                               top: top_digit(count_reg), last: !in_last};
                value_next = in_byte;
                count_next = COUNT_W'(1);
            end

            if (in_last)
            begin
                push.vld1  = 1'b1;
                push.rec1  = '{run_byte: value_next, count: count_next,
                               top: top_digit(count_next), last: 1'b1};
                value_next = '0;
                count_next = '0;
                open_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            count_reg <= '0;
            open_reg  <= 1'b0;
        end
        else
        begin
            value_reg <= value_next;
            count_reg <= count_next;
            open_reg  <= open_next;
        end
    end

endmodule

@@ hw/rtl/rte_serializer.sv @@
// Run record queue and the byte serializer with its output register.
module rte_serializer
    import rte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rte_push_t  push,
    output logic       full,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    localparam logic [POS_W-1:0] POS_RUN_BYTE = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TIMES    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DIGITS   = POS_W'(2);

    rte_run_rec_t          fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;

    rte_run_rec_t          head;
    logic                  load;
    logic                  end_of_run;
    logic                  in_digits;
    logic [DIG_IDX_W-1:0]  dig_idx;
    logic [3:0]            digit;
    logic [FIFO_CNT_W-1:0] n_push;

    // Room for two records is needed before another input beat is taken.
    assign full = (cnt_reg > FIFO_CNT_W'(FIFO_DEPTH - 2));

    assign head       = fifo_reg[rd_ptr_reg];
    assign load       = (cnt_reg != '0) && (!out_valid_reg || !out_stall);
    assign in_digits  = (pos_reg >= POS_DIGITS) &&
                        (pos_reg <= POS_W'(head.top) + POS_DIGITS);
    assign end_of_run = (pos_reg == POS_W'(head.top) + POS_W'(3));
    assign dig_idx    = head.top - DIG_IDX_W'(pos_reg - POS_DIGITS);
    assign digit      = head.count[4*dig_idx +: 4];
    assign n_push     = FIFO_CNT_W'(push.vld0) + FIFO_CNT_W'(push.vld1);

    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg + FIFO_PTR_W'(n_push);
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        cnt_next       = cnt_reg + n_push;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            priority if (pos_reg == POS_RUN_BYTE)
            begin
                out_byte_next = head.run_byte;
            end
            else if (pos_reg == POS_TIMES)
            begin
                out_byte_next = CHAR_X;
            end
            else if (in_digits)
            begin
                out_byte_next = CHAR_ZERO + {4'd0, digit};
            end
            else
            begin
                out_byte_next = CHAR_SPACE;
                out_last_next = head.last;
            end

            if (end_of_run)
            begin
                pos_next    = '0;
                rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(1);
                cnt_next    = cnt_reg + n_push - FIFO_CNT_W'(1);
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        if (push.vld0)
        begin
            fifo_reg[wr_ptr_reg] <= push.rec0;
        end
        if (push.vld1)
        begin
            fifo_reg[wr_ptr_reg + FIFO_PTR_W'(push.vld0)] <= push.rec1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

@@ hw/rtl/rle_text_encoder.sv @@
// Run-length text encoder: string bytes in, run-length text bytes out.
//
// Input channel: one string byte per beat on in_byte, with in_last set on the
// final byte of the string. Output channel: one text byte per beat on
// out_byte; out_last marks the final text byte caused by an input beat.
// Each finished run is sent as the run byte, 'x', the decimal count without
// leading zeros, and a space. A run that reaches 10^COUNT_DIGITS-1 is closed
// and a new run of the same byte starts.
// An input beat updates the open run in the cycle it is accepted and queues
// up to two finished runs. The first text byte of an idle block passes the
// run queue and then the output register before it is valid. The output side
// sends one byte per cycle while out_stall is low, and a run takes 4 to
// COUNT_DIGITS+3 text bytes. Beats that finish nothing are taken every
// cycle while the run queue has room for two runs.
// in_stall rises when the four-entry run queue cannot take two more runs.
// Reset empties the queue, drops the open run and clears out_valid.
// When out_stall is high the output register holds its byte and the queue
// keeps filling until in_stall pushes back.
module rle_text_encoder
    import rte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    rte_push_t push;
    logic      accept;

    assign accept = in_valid && !in_stall;

    rte_run_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .push    (push)
    );

    rte_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

@@ hw/rtl/rte_checker.sv @@
// Port-level checks for the run-length text encoder and their bind.
`include "rle_text_encoder_macros.svh"

module rte_checker
    import rte_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       out_last
);

    // Every group of text bytes for one input beat closes on a space.
    `RTE_ASSERT_NOW(a_last_is_space, out_valid && out_last, out_byte == CHAR_SPACE)

    // A final string byte always leaves text waiting once it has passed the run queue and the output register.
    `RTE_ASSERT_NOW(a_flush_shows, in_valid && !in_stall && in_last, ##2 out_valid)

    `RTE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    `RTE_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(out_byte) && $stable(out_last))

endmodule

bind rle_text_encoder rte_checker u_rte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
);
